FILE: rtl/core/bmas_pkg.sv
// package for the bresenham multi-axis step generator
// shared constants, command codes and the request, result and segment records
// no dependencies
package bmas_pkg;

   // sizes of the datapath
   localparam int QueueDepthDefault = 8;
   localparam int NumBlocks = 7;
   localparam int NumAxes = 3;
   localparam int BlkIdxW = 3;
   localparam int SegStepsW = 16;
   localparam int LevelW = 2;
   localparam int DirW = 3;
   localparam int StepsW = 32;
   localparam int AccW = StepsW + 1;
   localparam int PosW = 32;
   localparam int FreeW = 3;
   localparam int FreeMax = 7;

   // decoupling queues between the parts
   localparam int FifoDepth = 2;
   localparam int FifoPtrW = $clog2(FifoDepth);
   localparam int FifoCntW = $clog2(FifoDepth + 1);

   // register port
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic [CsrAddrW-1:0] CSR_DIR_INVERT = 3'd0;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_ENQUEUE = 2'd1,
      CMD_BLOCK   = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   // decoded request handed from the front to the execute side
   typedef struct packed {
      logic                 tick;
      logic                 enq;
      logic                 blk_wr;
      logic [BlkIdxW-1:0]   block_index;
      logic [SegStepsW-1:0] seg_steps;
      logic [LevelW-1:0]    smooth_level;
      logic [DirW-1:0]      dir_bits;
      logic [StepsW-1:0]    steps_x;
      logic [StepsW-1:0]    steps_y;
      logic [StepsW-1:0]    steps_z;
      logic [StepsW-1:0]    event_count;
   } item_type;

   // one queued segment
   typedef struct packed {
      logic [LevelW-1:0]    level;
      logic [BlkIdxW-1:0]   blk;
      logic [SegStepsW-1:0] steps;
   } seg_type;

   // one result
   typedef struct packed {
      logic [NumAxes-1:0]     step_pulses;
      logic [DirW-1:0]        dir_out;
      logic                   segment_done;
      logic                   idle;
      logic [FreeW-1:0]       free_slots;
      logic                   rejected;
      logic signed [PosW-1:0] pos_x;
      logic signed [PosW-1:0] pos_y;
      logic signed [PosW-1:0] pos_z;
   } res_type;

endpackage

FILE: rtl/core/bmas_fifo.sv
// two-entry decoupling queue, used for requests and for results
// depends on bmas_pkg for its depth constants
module bmas_fifo import bmas_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   logic [WIDTH-1:0]    mem_ff [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   // status and handshake
   assign full     = (cnt_ff == FifoCntW'(FifoDepth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   // pointer and fill count update, depth is a power of two so pointers wrap
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: rtl/core/bmas_front.sv
// front end: accepts requests, decodes the command and queues the decoded request
// depends on bmas_pkg and bmas_fifo
module bmas_front import bmas_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_cmd,
   input  logic [BlkIdxW-1:0]   req_block_index,
   input  logic [SegStepsW-1:0] req_seg_steps,
   input  logic [LevelW-1:0]    req_smooth_level,
   input  logic [DirW-1:0]      req_dir_bits,
   input  logic [StepsW-1:0]    req_steps_x,
   input  logic [StepsW-1:0]    req_steps_y,
   input  logic [StepsW-1:0]    req_steps_z,
   input  logic [StepsW-1:0]    req_event_count,
   output item_type             item,
   output logic                 item_valid,
   input  logic                 item_pop
);

   item_type dec;
   logic     iq_empty;

   // command decode, block slot seven is not a real slot
   always_comb begin
      dec              = '0;
      dec.block_index  = req_block_index;
      dec.seg_steps    = req_seg_steps;
      dec.smooth_level = req_smooth_level;
      dec.dir_bits     = req_dir_bits;
      dec.steps_x      = req_steps_x;
      dec.steps_y      = req_steps_y;
      dec.steps_z      = req_steps_z;
      dec.event_count  = req_event_count;
      case (cmd_type'(req_cmd))
         CMD_TICK: begin
            dec.tick = 1'b1;
         end
         CMD_ENQUEUE: begin
            dec.enq = 1'b1;
         end
         CMD_BLOCK: begin
            dec.blk_wr = (req_block_index < BlkIdxW'(NumBlocks));
         end
         default: begin
            dec.tick = 1'b0;
         end
      endcase
   end

   // queue towards the execute side
   bmas_fifo #(
      .WIDTH ($bits(item_type))
   ) u_iq (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .data_in  (dec),
      .full     (req_full),
      .pop      (item_pop),
      .data_out (item),
      .empty    (iq_empty)
   );

   assign item_valid = !iq_empty;

endmodule

FILE: rtl/core/bmas_back.sv
// execute side: segment ring queue, block table, bresenham counters and positions
// depends on bmas_pkg
module bmas_back import bmas_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  item_type        item,
   input  logic            item_valid,
   output logic            item_pop,
   input  logic [DirW-1:0] dir_flip,
   output res_type         res,
   output logic            res_push,
   input  logic            res_full
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] CntMax = CntW'(QUEUE_DEPTH - 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

   // segment queue
   seg_type           seg_mem_ff [QUEUE_DEPTH];
   seg_type           seg_head_ff;
   seg_type           seg_new;
   logic [PtrW-1:0]   head_ff, head_in;
   logic [PtrW-1:0]   tail_ff, tail_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   // block table
   logic [DirW-1:0]   blk_dir_ff [NumBlocks];
   logic [StepsW-1:0] blk_steps_ff [NumBlocks][NumAxes];
   logic [StepsW-1:0] blk_events_ff [NumBlocks];

   // counters and machine state
   logic [AccW-1:0]        acc_ff [NumAxes];
   logic [AccW-1:0]        acc_in [NumAxes];
   logic [StepsW-1:0]      inc_ff [NumAxes];
   logic [StepsW-1:0]      inc_in [NumAxes];
   logic signed [PosW-1:0] pos_ff [NumAxes];
   logic signed [PosW-1:0] pos_in [NumAxes];
   logic [SegStepsW-1:0]   steps_left_ff, steps_left_in;
   logic [BlkIdxW-1:0]     cur_block_ff, cur_block_in;
   logic [StepsW-1:0]      cur_ev_ff, cur_ev_in;
   logic                   loaded_ff, loaded_in;
   logic                   active_ff, active_in;
   logic [DirW-1:0]        dir_ff, dir_in;

   // working signals
   logic                 go;
   logic                 start, run, load, enq_ok;
   logic [BlkIdxW-1:0]   hb;
   logic [DirW-1:0]      tbl_dir;
   logic [StepsW-1:0]    tbl_steps [NumAxes];
   logic [StepsW-1:0]    tbl_ev;
   logic [StepsW-1:0]    ev_use;
   logic [SegStepsW-1:0] steps_base;
   logic [AccW-1:0]      acc_base [NumAxes];
   logic [AccW-1:0]      sum [NumAxes];
   logic [AccW-1:0]      diff [NumAxes];
   logic [NumAxes-1:0]   pulses;
   logic                 done, idle, rej;
   logic [CntW-1:0]      free_w;

   assign go       = item_valid && !res_full;
   assign item_pop = go;
   assign res_push = go;

   assign seg_new.level = item.smooth_level;
   assign seg_new.blk   = item.block_index;
   assign seg_new.steps = item.seg_steps;

   // block table read for the segment at the head of the queue, slot seven reads zero
   assign hb = seg_head_ff.blk;
   always_comb begin
      tbl_dir = '0;
      tbl_ev  = '0;
      for (int a = 0; a < NumAxes; a++) begin
         tbl_steps[a] = '0;
      end
      if (hb < BlkIdxW'(NumBlocks)) begin
         tbl_dir = blk_dir_ff[hb];
         tbl_ev  = blk_events_ff[hb];
         for (int a = 0; a < NumAxes; a++) begin
            tbl_steps[a] = blk_steps_ff[hb][a];
         end
      end
   end

   // request execution
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      steps_left_in = steps_left_ff;
      cur_block_in  = cur_block_ff;
      cur_ev_in     = cur_ev_ff;
      loaded_in     = loaded_ff;
      active_in     = active_ff;
      dir_in        = dir_ff;
      start         = 1'b0;
      run           = 1'b0;
      load          = 1'b0;
      enq_ok        = 1'b0;
      pulses        = '0;
      done          = 1'b0;
      idle          = 1'b0;
      rej           = 1'b0;
      ev_use        = cur_ev_ff;
      steps_base    = steps_left_ff;
      for (int a = 0; a < NumAxes; a++) begin
         acc_in[a]   = acc_ff[a];
         inc_in[a]   = inc_ff[a];
         pos_in[a]   = pos_ff[a];
         acc_base[a] = acc_ff[a];
         sum[a]      = '0;
         diff[a]     = '0;
      end

      if (go && item.tick) begin
         start = !active_ff && (cnt_ff != '0);
         run   = start || active_ff;
         idle  = !run;
         // segment start: latch direction and increments, reload counters on a new block
         if (start) begin
            load         = !loaded_ff || (cur_block_ff != hb);
            steps_base   = (seg_head_ff.steps == '0) ? SegStepsW'(1) : seg_head_ff.steps;
            ev_use       = tbl_ev;
            dir_in       = tbl_dir;
            cur_block_in = hb;
            cur_ev_in    = tbl_ev;
            loaded_in    = 1'b1;
            for (int a = 0; a < NumAxes; a++) begin
               inc_in[a] = tbl_steps[a] >> seg_head_ff.level;
               if (load) begin
                  acc_base[a] = {2'b00, tbl_ev[StepsW-1:1]};
               end
            end
         end
         // one bresenham event on each axis
         if (run) begin
            for (int a = 0; a < NumAxes; a++) begin
               sum[a]  = acc_base[a] + {1'b0, inc_in[a]};
               diff[a] = sum[a] - {1'b0, ev_use};
               if (sum[a] > {1'b0, ev_use}) begin
                  pulses[a] = 1'b1;
                  acc_in[a] = diff[a];
                  pos_in[a] = dir_in[a] ? pos_ff[a] - 32'sd1 : pos_ff[a] + 32'sd1;
               end else begin
                  acc_in[a] = sum[a];
               end
            end
            steps_left_in = steps_base - 1'b1;
            if (steps_left_in == '0) begin
               done      = 1'b1;
               active_in = 1'b0;
               tail_in   = (tail_ff == PtrLast) ? '0 : tail_ff + 1'b1;
               cnt_in    = cnt_ff - 1'b1;
            end else begin
               active_in = 1'b1;
            end
         end
      end else if (go && item.enq) begin
         // segment enqueue, refused when the ring is full
         if (cnt_ff == CntMax) begin
            rej = 1'b1;
         end else begin
            enq_ok  = 1'b1;
            head_in = (head_ff == PtrLast) ? '0 : head_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
         end
      end else if (go && item.blk_wr) begin
         // keep the cached event count of the running block in step with the table
         if (item.block_index == cur_block_ff) begin
            cur_ev_in = item.event_count;
         end
      end
   end

   // result record
   assign free_w = CntMax - cnt_in;
   always_comb begin
      res              = '0;
      res.step_pulses  = pulses;
      res.dir_out      = dir_in ^ dir_flip;
      res.segment_done = done;
      res.idle         = idle;
      res.free_slots   = (32'(free_w) > 32'(FreeMax)) ? FreeW'(FreeMax) : FreeW'(free_w);
      res.rejected     = rej;
      res.pos_x        = pos_in[0];
      res.pos_y        = pos_in[1];
      res.pos_z        = pos_in[2];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         cnt_ff        <= '0;
         steps_left_ff <= '0;
         cur_block_ff  <= '0;
         cur_ev_ff     <= '0;
         loaded_ff     <= 1'b0;
         active_ff     <= 1'b0;
         dir_ff        <= '0;
         for (int a = 0; a < NumAxes; a++) begin
            acc_ff[a] <= '0;
            inc_ff[a] <= '0;
            pos_ff[a] <= '0;
         end
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
         steps_left_ff <= steps_left_in;
         cur_block_ff  <= cur_block_in;
         cur_ev_ff     <= cur_ev_in;
         loaded_ff     <= loaded_in;
         active_ff     <= active_in;
         dir_ff        <= dir_in;
         for (int a = 0; a < NumAxes; a++) begin
            acc_ff[a] <= acc_in[a];
            inc_ff[a] <= inc_in[a];
            pos_ff[a] <= pos_in[a];
         end
      end
   end

   // segment ring write
   always_ff @(posedge clock) begin
      if (enq_ok) begin
         seg_mem_ff[head_ff] <= seg_new;
      end
   end

   // registered read of the oldest segment, with write-through into an empty ring
   always_ff @(posedge clock) begin
      if (enq_ok && (head_ff == tail_in)) begin
         seg_head_ff <= seg_new;
      end else begin
         seg_head_ff <= seg_mem_ff[tail_in];
      end
   end

   // block table write
   always_ff @(posedge clock) begin
      if (go && item.blk_wr) begin
         blk_dir_ff[item.block_index]       <= item.dir_bits;
         blk_steps_ff[item.block_index][0]  <= item.steps_x;
         blk_steps_ff[item.block_index][1]  <= item.steps_y;
         blk_steps_ff[item.block_index][2]  <= item.steps_z;
         blk_events_ff[item.block_index]    <= item.event_count;
      end
   end

   // checks
   a_active_has_segment: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cnt_ff != '0))
      else $error("segment running with an empty ring");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      (go && done) |=> !active_ff)
      else $error("segment still running after completion");

   a_done_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (go && done) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("completed segment did not free its ring slot");

   a_idle_only_empty: assert property (@(posedge clock) disable iff (reset)
      (go && idle) |-> ((cnt_ff == '0) && !active_ff))
      else $error("idle tick with work pending");

   a_reject_only_full: assert property (@(posedge clock) disable iff (reset)
      (go && rej) |=> (cnt_ff == CntMax))
      else $error("enqueue refused while ring had room");

endmodule

FILE: rtl/core/bresenham_multi_axis_step_generator.sv
// Three-axis Bresenham step generator with a segment ring queue and a block table.
// Requests are taken at one per cycle when req_full is low, and each gives exactly one
// result, which can be popped once registered in the result queue. A request passes a
// two-entry decode queue, then the execute stage that starts the next segment if needed
// and runs the three 33-bit accumulate-and-compare steps, then a two-entry result queue.
// The execute stage is the only place a request waits on the prior one, so the sustained
// rate is one request per cycle while results are drained. No clearing pass after reset.
// depends on bmas_pkg, bmas_front, bmas_back and bmas_fifo
module bresenham_multi_axis_step_generator import bmas_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_cmd,
   input  logic [BlkIdxW-1:0]     req_block_index,
   input  logic [SegStepsW-1:0]   req_seg_steps,
   input  logic [LevelW-1:0]      req_smooth_level,
   input  logic [DirW-1:0]        req_dir_bits,
   input  logic [StepsW-1:0]      req_steps_x,
   input  logic [StepsW-1:0]      req_steps_y,
   input  logic [StepsW-1:0]      req_steps_z,
   input  logic [StepsW-1:0]      req_event_count,
   // result side
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [NumAxes-1:0]     rsp_step_pulses,
   output logic [DirW-1:0]        rsp_dir_out,
   output logic                   rsp_segment_done,
   output logic                   rsp_idle,
   output logic [FreeW-1:0]       rsp_free_slots,
   output logic                   rsp_rejected,
   output logic signed [PosW-1:0] rsp_pos_x,
   output logic signed [PosW-1:0] rsp_pos_y,
   output logic signed [PosW-1:0] rsp_pos_z,
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrW-1:0]    csr_paddr,
   input  logic [CsrDataW-1:0]    csr_pwdata,
   output logic [CsrDataW-1:0]    csr_prdata,
   output logic                   csr_pready
);

   item_type        item;
   logic            item_valid, item_pop;
   res_type         res, rsp_res;
   logic            res_push, res_full;
   logic [DirW-1:0] mask_ff, mask_in;

   // register port, single direction invert register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_DIR_INVERT) ? CsrDataW'(mask_ff) : '0;

   always_comb begin
      mask_in = mask_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr == CSR_DIR_INVERT)) begin
         mask_in = csr_pwdata[DirW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // decode and request queue
   bmas_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_block_index  (req_block_index),
      .req_seg_steps    (req_seg_steps),
      .req_smooth_level (req_smooth_level),
      .req_dir_bits     (req_dir_bits),
      .req_steps_x      (req_steps_x),
      .req_steps_y      (req_steps_y),
      .req_steps_z      (req_steps_z),
      .req_event_count  (req_event_count),
      .item             (item),
      .item_valid       (item_valid),
      .item_pop         (item_pop)
   );

   // execute
   bmas_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .dir_flip   (mask_ff),
      .res        (res),
      .res_push   (res_push),
      .res_full   (res_full)
   );

   // result queue
   bmas_fifo #(
      .WIDTH ($bits(res_type))
   ) u_rq (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .data_in  (res),
      .full     (res_full),
      .pop      (rsp_pop),
      .data_out (rsp_res),
      .empty    (rsp_empty)
   );

   assign rsp_step_pulses  = rsp_res.step_pulses;
   assign rsp_dir_out      = rsp_res.dir_out;
   assign rsp_segment_done = rsp_res.segment_done;
   assign rsp_idle         = rsp_res.idle;
   assign rsp_free_slots   = rsp_res.free_slots;
   assign rsp_rejected     = rsp_res.rejected;
   assign rsp_pos_x        = rsp_res.pos_x;
   assign rsp_pos_y        = rsp_res.pos_y;
   assign rsp_pos_z        = rsp_res.pos_z;

endmodule

FILE: verif/tb.sv
// self-checking testbench for the bresenham multi-axis step generator
// predicts every result from its own copy of the block state and checks it field by field
// depends on bmas_pkg and bresenham_multi_axis_step_generator
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bmas_pkg::*;

   localparam int QDepth = QueueDepthDefault;

   // one request as the testbench sees it
   typedef struct packed {
      cmd_type              cmd;
      logic [BlkIdxW-1:0]   block_index;
      logic [SegStepsW-1:0] seg_steps;
      logic [LevelW-1:0]    smooth_level;
      logic [DirW-1:0]      dir_bits;
      logic [StepsW-1:0]    steps_x;
      logic [StepsW-1:0]    steps_y;
      logic [StepsW-1:0]    steps_z;
      logic [StepsW-1:0]    event_count;
   } motion_req_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   // block ports, all known from time zero
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [1:0]             req_cmd = '0;
   logic [BlkIdxW-1:0]     req_block_index = '0;
   logic [SegStepsW-1:0]   req_seg_steps = '0;
   logic [LevelW-1:0]      req_smooth_level = '0;
   logic [DirW-1:0]        req_dir_bits = '0;
   logic [StepsW-1:0]      req_steps_x = '0;
   logic [StepsW-1:0]      req_steps_y = '0;
   logic [StepsW-1:0]      req_steps_z = '0;
   logic [StepsW-1:0]      req_event_count = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [NumAxes-1:0]     rsp_step_pulses;
   logic [DirW-1:0]        rsp_dir_out;
   logic                   rsp_segment_done;
   logic                   rsp_idle;
   logic [FreeW-1:0]       rsp_free_slots;
   logic                   rsp_rejected;
   logic signed [PosW-1:0] rsp_pos_x;
   logic signed [PosW-1:0] rsp_pos_y;
   logic signed [PosW-1:0] rsp_pos_z;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0]    csr_paddr = '0;
   logic [CsrDataW-1:0]    csr_pwdata = '0;
   logic [CsrDataW-1:0]    csr_prdata;
   logic                   csr_pready;

   bresenham_multi_axis_step_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_block_index  (req_block_index),
      .req_seg_steps    (req_seg_steps),
      .req_smooth_level (req_smooth_level),
      .req_dir_bits     (req_dir_bits),
      .req_steps_x      (req_steps_x),
      .req_steps_y      (req_steps_y),
      .req_steps_z      (req_steps_z),
      .req_event_count  (req_event_count),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_step_pulses  (rsp_step_pulses),
      .rsp_dir_out      (rsp_dir_out),
      .rsp_segment_done (rsp_segment_done),
      .rsp_idle         (rsp_idle),
      .rsp_free_slots   (rsp_free_slots),
      .rsp_rejected     (rsp_rejected),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // request backlog, due results and run controls
   motion_req_type req_backlog_q[$];
   res_type        motion_due_q[$];
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   bit             hold_off = 1'b0;
   int             errors = 0;
   int             n_sent = 0;
   int             n_results = 0;
   int             n_done = 0;
   int             n_refused = 0;
   int             n_stepping = 0;

   // predicted block state, reset values as after reset
   seg_type           ring_seg [QDepth];
   logic [DirW-1:0]   blk_dir_tbl [NumBlocks];
   logic [StepsW-1:0] blk_steps_tbl [NumBlocks][NumAxes];
   logic [StepsW-1:0] blk_events_tbl [NumBlocks];
   logic [AccW-1:0]   acc [NumAxes] = '{default: '0};
   logic [StepsW-1:0] inc [NumAxes] = '{default: '0};
   logic [PosW-1:0]   pos [NumAxes] = '{default: '0};
   logic [SegStepsW-1:0] seg_left = '0;
   logic [BlkIdxW-1:0] run_blk = '0;
   bit                blk_loaded = 1'b0;
   bit                seg_running = 1'b0;
   int                ring_head = 0;
   int                ring_tail = 0;
   logic [DirW-1:0]   dir_latched = '0;
   logic [DirW-1:0]   invert_mask = '0;

   // event count of a slot, slot seven reads as zero
   function automatic logic [StepsW-1:0] events_of(input logic [BlkIdxW-1:0] b);
      return (b < NumBlocks) ? blk_events_tbl[b] : '0;
   endfunction

   // apply one request to the predicted state and form its result
   task automatic advance_motion(input motion_req_type r, output res_type res);
      logic [NumAxes-1:0] pulses;
      logic               done;
      logic               no_seg;
      logic               refused;
      logic [StepsW-1:0]  ev;
      seg_type            s;
      int                 used;
      int                 free;
      int                 i;
      pulses = '0;
      done = 1'b0;
      no_seg = 1'b0;
      refused = 1'b0;
      used = (ring_head - ring_tail + QDepth) % QDepth;
      case (r.cmd)
         CMD_TICK: begin
            // start the next queued segment when nothing runs
            if (!seg_running && ring_head != ring_tail) begin
               s = ring_seg[ring_tail];
               seg_left = (s.steps == '0) ? 16'd1 : s.steps;
               // a change of block, or the first block, reloads the counters
               if (!blk_loaded || run_blk != s.blk) begin
                  run_blk = s.blk;
                  blk_loaded = 1'b1;
                  for (i = 0; i < NumAxes; i++)
                     acc[i] = {1'b0, events_of(s.blk)} >> 1;
               end
               dir_latched = (s.blk < NumBlocks) ? blk_dir_tbl[s.blk] : '0;
               for (i = 0; i < NumAxes; i++)
                  inc[i] = ((s.blk < NumBlocks) ? blk_steps_tbl[s.blk][i] : '0) >> s.level;
               seg_running = 1'b1;
            end
            if (!seg_running) begin
               no_seg = 1'b1;
            end else begin
               // one bresenham event on every axis
               ev = events_of(run_blk);
               for (i = 0; i < NumAxes; i++) begin
                  acc[i] = acc[i] + {1'b0, inc[i]};
                  if (acc[i] > {1'b0, ev}) begin
                     acc[i] = acc[i] - {1'b0, ev};
                     pos[i] = dir_latched[i] ? pos[i] - 1 : pos[i] + 1;
                     pulses[i] = 1'b1;
                  end
               end
               seg_left = seg_left - 1'b1;
               if (seg_left == '0) begin
                  seg_running = 1'b0;
                  ring_tail = (ring_tail + 1) % QDepth;
                  done = 1'b1;
               end
            end
         end
         CMD_ENQUEUE: begin
            if (used >= QDepth - 1) begin
               refused = 1'b1;
            end else begin
               s.level = r.smooth_level;
               s.blk = r.block_index;
               s.steps = r.seg_steps;
               ring_seg[ring_head] = s;
               ring_head = (ring_head + 1) % QDepth;
            end
         end
         CMD_BLOCK: begin
            if (r.block_index < NumBlocks) begin
               blk_dir_tbl[r.block_index] = r.dir_bits;
               blk_steps_tbl[r.block_index][0] = r.steps_x;
               blk_steps_tbl[r.block_index][1] = r.steps_y;
               blk_steps_tbl[r.block_index][2] = r.steps_z;
               blk_events_tbl[r.block_index] = r.event_count;
            end
         end
         default: ;
      endcase
      used = (ring_head - ring_tail + QDepth) % QDepth;
      free = QDepth - 1 - used;
      if (free > FreeMax)
         free = FreeMax;
      res.step_pulses = pulses;
      res.dir_out = dir_latched ^ invert_mask;
      res.segment_done = done;
      res.idle = no_seg;
      res.free_slots = FreeW'(free);
      res.rejected = refused;
      res.pos_x = pos[0];
      res.pos_y = pos[1];
      res.pos_z = pos[2];
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
      end
   endtask

   task automatic check_result(input res_type want, input res_type got);
      check_field("step_pulses", 32'(want.step_pulses), 32'(got.step_pulses));
      check_field("dir_out", 32'(want.dir_out), 32'(got.dir_out));
      check_field("segment_done", 32'(want.segment_done), 32'(got.segment_done));
      check_field("idle", 32'(want.idle), 32'(got.idle));
      check_field("free_slots", 32'(want.free_slots), 32'(got.free_slots));
      check_field("rejected", 32'(want.rejected), 32'(got.rejected));
      check_field("pos_x", want.pos_x, got.pos_x);
      check_field("pos_y", want.pos_y, got.pos_y);
      check_field("pos_z", want.pos_z, got.pos_z);
   endtask

   // request driver: predicts on acceptance, then offers the next request
   always @(posedge clock) begin : driver
      bit             stuck;
      bit             go;
      motion_req_type r;
      res_type        want;
      if (!reset) begin
         stuck = 1'b0;
         if (req_push) begin
            if (!req_full) begin
               advance_motion(req_backlog_q[0], want);
               motion_due_q.push_back(want);
               req_backlog_q.delete(0);
               n_sent++;
            end else begin
               stuck = 1'b1;
            end
         end
         go = stuck || (req_backlog_q.size() != 0 && !hold_off &&
                        $urandom_range(0, 99) >= send_idle_pct);
         if (go) begin
            r = req_backlog_q[0];
            req_cmd <= r.cmd;
            req_block_index <= r.block_index;
            req_seg_steps <= r.seg_steps;
            req_smooth_level <= r.smooth_level;
            req_dir_bits <= r.dir_bits;
            req_steps_x <= r.steps_x;
            req_steps_y <= r.steps_y;
            req_steps_z <= r.steps_z;
            req_event_count <= r.event_count;
         end
         req_push <= go;
      end
   end

   // result monitor: compares against the oldest due result
   always @(posedge clock) begin : monitor
      res_type got;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            got.step_pulses = rsp_step_pulses;
            got.dir_out = rsp_dir_out;
            got.segment_done = rsp_segment_done;
            got.idle = rsp_idle;
            got.free_slots = rsp_free_slots;
            got.rejected = rsp_rejected;
            got.pos_x = rsp_pos_x;
            got.pos_y = rsp_pos_y;
            got.pos_z = rsp_pos_z;
            n_results++;
            if (got.segment_done) n_done++;
            if (got.rejected) n_refused++;
            if (got.step_pulses != '0) n_stepping++;
            if (motion_due_q.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            end else begin
               check_result(motion_due_q[0], got);
               motion_due_q.delete(0);
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // one register transfer: setup, access, complete on pready
   task automatic csr_cycle(input bit wr, input logic [CsrDataW-1:0] wdata,
                            output logic [CsrDataW-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= CSR_DIR_INVERT;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // write the invert mask with junk in the upper bits, then read it back
   task automatic set_invert_mask(input logic [DirW-1:0] value);
      logic [CsrDataW-1:0] word;
      logic [CsrDataW-1:0] rd;
      word = $urandom();
      word[DirW-1:0] = value;
      csr_cycle(1'b1, word, rd);
      invert_mask = value;
      csr_cycle(1'b0, '0, rd);
      check_field("direction mask readback", 32'(value), 32'(rd[DirW-1:0]));
   endtask

   // request with every field random
   function automatic motion_req_type scrambled(input cmd_type c);
      motion_req_type r;
      r.cmd = c;
      r.block_index = BlkIdxW'($urandom_range(0, 7));
      r.seg_steps = SegStepsW'($urandom());
      r.smooth_level = LevelW'($urandom_range(0, 3));
      r.dir_bits = DirW'($urandom_range(0, 7));
      r.steps_x = $urandom();
      r.steps_y = $urandom();
      r.steps_z = $urandom();
      r.event_count = $urandom();
      return r;
   endfunction

   function automatic motion_req_type block_req(input logic [BlkIdxW-1:0] idx,
                                                input logic [DirW-1:0] dir,
                                                input logic [StepsW-1:0] sx,
                                                input logic [StepsW-1:0] sy,
                                                input logic [StepsW-1:0] sz,
                                                input logic [StepsW-1:0] ev);
      motion_req_type r;
      r = scrambled(CMD_BLOCK);
      r.block_index = idx;
      r.dir_bits = dir;
      r.steps_x = sx;
      r.steps_y = sy;
      r.steps_z = sz;
      r.event_count = ev;
      return r;
   endfunction

   function automatic motion_req_type segment_req(input logic [SegStepsW-1:0] n,
                                                  input logic [BlkIdxW-1:0] idx,
                                                  input logic [LevelW-1:0] lvl);
      motion_req_type r;
      r = scrambled(CMD_ENQUEUE);
      r.seg_steps = n;
      r.block_index = idx;
      r.smooth_level = lvl;
      return r;
   endfunction

   // block with a dominant axis and small counts, or wide random counts
   function automatic motion_req_type random_block(input logic [BlkIdxW-1:0] idx);
      motion_req_type r;
      int unsigned    ev;
      r = scrambled(CMD_BLOCK);
      r.block_index = idx;
      if ($urandom_range(0, 3) != 0) begin
         ev = $urandom_range(1, 300);
         r.event_count = ev;
         r.steps_x = $urandom_range(0, ev);
         r.steps_y = $urandom_range(0, ev);
         r.steps_z = $urandom_range(0, ev);
         case ($urandom_range(0, 2))
            0: r.steps_x = ev;
            1: r.steps_y = ev;
            default: r.steps_z = ev;
         endcase
      end
      return r;
   endfunction

   function automatic motion_req_type random_segment();
      motion_req_type r;
      r = scrambled(CMD_ENQUEUE);
      r.seg_steps = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
      return r;
   endfunction

   // stray requests: unused command, slot seven, extra stores and enqueues
   function automatic motion_req_type noise_req();
      motion_req_type r;
      case ($urandom_range(0, 3))
         0: r = scrambled(CMD_NONE);
         1: begin
            r = scrambled(CMD_BLOCK);
            r.block_index = 3'd7;
         end
         2: r = random_segment();
         default: r = random_block(BlkIdxW'($urandom_range(0, 6)));
      endcase
      return r;
   endfunction

   // an optional block store, a run of segments and enough ticks to play them out
   task automatic queue_burst(output int n);
      int             pick;
      int             nseg;
      int             ticks;
      int             k;
      motion_req_type r;
      n = 0;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         req_backlog_q.push_back(random_block(BlkIdxW'($urandom_range(0, 6))));
         n++;
      end
      // now and then flood the queue past full
      nseg = (pick == 9) ? QDepth + 1 : $urandom_range(1, 4);
      ticks = $urandom_range(0, 3);
      for (k = 0; k < nseg; k++) begin
         r = random_segment();
         ticks += (r.seg_steps == '0) ? 1 : r.seg_steps;
         req_backlog_q.push_back(r);
         n++;
      end
      for (k = 0; k < ticks; k++) begin
         if ($urandom_range(0, 11) == 0) begin
            req_backlog_q.push_back(noise_req());
            n++;
         end
         req_backlog_q.push_back(scrambled(CMD_TICK));
         n++;
      end
   endtask

   // wait until every request is in and every result is out
   task automatic drain_all();
      while (req_backlog_q.size() != 0 || req_push || motion_due_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct,
                            input logic [DirW-1:0] mask, input int target,
                            input bit pause_mid);
      int added;
      int n;
      set_invert_mask(mask);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      added = 0;
      while (added < target) begin
         queue_burst(n);
         added += n;
      end
      // hold the sender midway until all results are back
      if (pause_mid) begin
         while (req_backlog_q.size() > added / 2) @(posedge clock);
         hold_off = 1'b1;
         while (req_push || motion_due_q.size() != 0) @(posedge clock);
         repeat (5) @(posedge clock);
         hold_off = 1'b0;
      end
      drain_all();
   endtask

   initial begin : stimulus
      int k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unused command and idle tick before any block exists
      set_invert_mask(3'd0);
      req_backlog_q.push_back(scrambled(CMD_NONE));
      req_backlog_q.push_back(scrambled(CMD_TICK));
      // fill every block slot, with the extremes of the counts
      req_backlog_q.push_back(block_req(3'd0, 3'd0, '1, '1, '1, '1));
      req_backlog_q.push_back(block_req(3'd1, 3'd7, '0, '0, '0, '0));
      req_backlog_q.push_back(block_req(3'd2, 3'd5, 32'd10, 32'd4, 32'd7, 32'd10));
      req_backlog_q.push_back(block_req(3'd3, 3'd2, 32'd6, 32'd3, 32'd1, 32'd6));
      req_backlog_q.push_back(block_req(3'd4, 3'd1, 32'd0, '1, 32'd1, 32'd1));
      req_backlog_q.push_back(block_req(3'd5, 3'd3, 32'd40, 32'd17, 32'd40, 32'd40));
      req_backlog_q.push_back(block_req(3'd6, 3'd6, 32'd9, 32'd25, 32'd2, 32'd25));
      // a store to slot seven is dropped
      req_backlog_q.push_back(block_req(3'd7, 3'd7, '1, '1, '1, '1));
      // zero step count, same block again, slot seven, wide counters
      req_backlog_q.push_back(segment_req(16'd0, 3'd2, 2'd0));
      req_backlog_q.push_back(segment_req(16'd3, 3'd2, 2'd1));
      req_backlog_q.push_back(segment_req(16'd2, 3'd7, 2'd3));
      req_backlog_q.push_back(segment_req(16'd2, 3'd0, 2'd0));
      req_backlog_q.push_back(segment_req(16'd1, 3'd1, 2'd2));
      req_backlog_q.push_back(segment_req(16'd2, 3'd4, 2'd0));
      for (k = 0; k < 12; k++)
         req_backlog_q.push_back(scrambled(CMD_TICK));
      drain_all();

      // random phases over idling patterns and mask settings
      run_phase(0, 0, 3'd7, 120, 1'b0);
      run_phase(49, 0, 3'd5, 120, 1'b1);
      run_phase(0, 49, 3'd2, 120, 1'b0);
      run_phase(26, 26, 3'd0, 120, 1'b0);

      // longest segment with the queue pushed past full behind it
      set_invert_mask(3'd7);
      req_backlog_q.push_back(segment_req(16'hFFFF, 3'd3, 2'd3));
      for (k = 0; k < QDepth; k++)
         req_backlog_q.push_back(random_segment());
      for (k = 0; k < 40; k++)
         req_backlog_q.push_back(scrambled(CMD_TICK));
      req_backlog_q.push_back(random_segment());
      req_backlog_q.push_back(scrambled(CMD_TICK));
      drain_all();
      repeat (20) @(posedge clock);

      if (motion_due_q.size() != 0) begin
         errors++;
         $display("%0t ns: %0d results never arrived, expected 0, actual %0d",
                  $time, motion_due_q.size(), motion_due_q.size());
      end
      $display("summary: %0d requests, %0d results checked, %0d segments finished",
               n_sent, n_results, n_done);
      $display("summary: %0d ticks with steps, %0d enqueues refused, %0d errors",
               n_stepping, n_refused, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
